// ----- rtl/core/siu_pkg.sv -----
// Shared types and constants for the stack instruction unit.
package siu_pkg;

	// Stack depth and processor status bits
	localparam int SIU_STACK_DEPTH = 256;
	localparam logic [7:0] SIU_SP_RESET = 8'hFD;
	localparam logic [7:0] FLAG_N = 8'h80;
	localparam logic [7:0] FLAG_U = 8'h20;
	localparam logic [7:0] FLAG_B = 8'h10;
	localparam logic [7:0] FLAG_I = 8'h04;
	localparam logic [7:0] FLAG_Z = 8'h02;

	// Causes of interrupt entry
	localparam logic [1:0] KIND_BRK = 2'd0;
	localparam logic [1:0] KIND_NMI = 2'd2;

	// Configuration register indexes
	localparam logic CFG_NMI_VECTOR = 1'b0;
	localparam logic CFG_IRQ_BRK_VECTOR = 1'b1;

	// Stack instruction codes
	typedef enum logic [2:0] {
		REQ_ENTRY = 3'd0,
		REQ_RTI = 3'd1,
		REQ_RTS = 3'd2,
		REQ_PHA = 3'd3,
		REQ_PHP = 3'd4,
		REQ_PLA = 3'd5,
		REQ_PLP = 3'd6,
		REQ_JSR = 3'd7
	} siu_req_t;

	// Sequencer states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_ACCESS,
		ST_FINISH
	} siu_state_t;

	// One access to the stack RAM
	typedef struct packed {
		logic en;
		logic we;
		logic [7:0] addr;
		logic [7:0] wdata;
	} siu_ram_req_t;

endpackage

// ----- rtl/core/siu_stack_ram.sv -----
// Single-port page-one stack RAM with per-entry valid bits for the cleared reset state.
module siu_stack_ram
	import siu_pkg::*;
#(
	parameter int STACK_DEPTH = SIU_STACK_DEPTH
) (
	input  logic         clk,
	input  logic         arst_n,
	input  siu_ram_req_t req,
	output logic [7:0]   rdata
);

	localparam int AW = $clog2(STACK_DEPTH);

	logic [7:0] mem [STACK_DEPTH];
	logic [STACK_DEPTH-1:0] valid_q;
	logic [7:0] rdata_q;
	logic rvalid_q;
	logic [AW-1:0] addr;

	assign addr = req.addr[AW-1:0];

	// Storage array: one write or one registered read per cycle.
	always_ff @(posedge clk) begin
		if (req.en) begin
			if (req.we) begin
				mem[addr] <= req.wdata;
			end else begin
				rdata_q <= mem[addr];
			end
		end
	end

	// Valid bits: an entry never written reads as zero.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			rvalid_q <= 1'b0;
		end else if (req.en) begin
			if (req.we) begin
				valid_q[addr] <= 1'b1;
			end else begin
				rvalid_q <= valid_q[addr];
			end
		end
	end

	assign rdata = rvalid_q ? rdata_q : 8'h00;

endmodule

// ----- rtl/core/stack_instruction_unit_top.sv -----
// Top level of the stack instruction unit: sequencer, shared pointer adder and result register.
// Sequence: after its word is accepted, an instruction makes n stack accesses, n being 1 for
// PHA, PHP, PLA and PLP, 2 for RTS and JSR, 3 for entry and RTI; the single-port stack RAM
// takes one access per cycle. The sequencer then waits in the finish state until the output
// register can load the result; a new word is accepted only while the sequencer is idle.
// Reset: arst_n clears the stack RAM at once, sets S to 0xFD and both vectors to zero.
module stack_instruction_unit_top
	import siu_pkg::*;
#(
	parameter int STACK_DEPTH = SIU_STACK_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	// Input stream
	input  logic        s_tvalid,
	output logic        s_tready,
	// pc_in[15:0], acc_in[23:16], status_in[31:24], jump_target[47:32],
	// entry_kind[49:48], nmi_pending[50], irq_pending[51], zero fill[55:52]
	input  logic [55:0] s_tdata,
	// req_type[2:0]
	input  logic [2:0]  s_tuser,
	// Result stream
	output logic        m_tvalid,
	input  logic        m_tready,
	// pc_out[15:0], acc_out[23:16], status_out[31:24], sp_out[39:32],
	// nmi_taken[40], delay_set[41], delay_value[42], zero fill[47:43]
	output logic [47:0] m_tdata,
	// Configuration write port
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [15:0] cfg_data
);

	siu_state_t state_q, state_d;
	siu_req_t req_q, req_in;
	logic [7:0] sp_q, sp_step;
	logic [1:0] step_q, nacc_q, nacc_in;
	logic is_push_q, is_push_in;
	logic [15:0] pc_q, tgt_q;
	logic [7:0] acc_q, st_q;
	logic [1:0] kind_q;
	logic nmi_q;
	logic [7:0] push_byte_q [3];
	logic [7:0] push_byte_in [3];
	logic [7:0] pulled_q [3];
	logic [7:0] pull_v [3];
	logic rd_pending_q;
	logic [1:0] rd_idx_q;
	logic [15:0] nmi_vec_q, irq_vec_q;
	siu_ram_req_t ram_req;
	logic [7:0] ram_rdata;
	logic accept, load_out, last_step;
	logic out_valid_q;
	logic [42:0] out_q, res;

	// Input field views
	logic [15:0] in_pc, in_tgt, in_pc_inc, entry_pc;
	logic [7:0] in_acc, in_st;
	logic [1:0] in_kind;
	logic in_brk;

	assign in_pc = s_tdata[15:0];
	assign in_acc = s_tdata[23:16];
	assign in_st = s_tdata[31:24];
	assign in_tgt = s_tdata[47:32];
	assign in_kind = s_tdata[49:48];
	assign req_in = siu_req_t'(s_tuser);
	assign in_pc_inc = in_pc + 16'd1;
	assign in_brk = (in_kind == KIND_BRK);
	assign entry_pc = in_brk ? in_pc_inc : in_pc;

	assign s_tready = (state_q == ST_IDLE);
	assign accept = s_tvalid && s_tready;

	// Access plan: bytes to push, number of accesses and direction.
	always_comb begin
		push_byte_in[0] = in_acc;
		push_byte_in[1] = 8'h00;
		push_byte_in[2] = 8'h00;
		nacc_in = 2'd1;
		is_push_in = 1'b0;
		unique case (req_in)
			REQ_ENTRY: begin
				push_byte_in[0] = entry_pc[15:8];
				push_byte_in[1] = entry_pc[7:0];
				push_byte_in[2] = in_st | FLAG_U | (in_brk ? FLAG_B : 8'h00);
				nacc_in = 2'd3;
				is_push_in = 1'b1;
			end
			REQ_RTI: nacc_in = 2'd3;
			REQ_RTS: nacc_in = 2'd2;
			REQ_PHA: is_push_in = 1'b1;
			REQ_PHP: begin
				push_byte_in[0] = in_st | FLAG_U | FLAG_B;
				is_push_in = 1'b1;
			end
			REQ_PLA, REQ_PLP: nacc_in = 2'd1;
			REQ_JSR: begin
				push_byte_in[0] = in_pc_inc[15:8];
				push_byte_in[1] = in_pc_inc[7:0];
				nacc_in = 2'd2;
				is_push_in = 1'b1;
			end
			default: nacc_in = 2'd1;
		endcase
	end

	// Shared pointer adder: decrement after a push, increment before a pull.
	assign sp_step = sp_q + (is_push_q ? 8'hFF : 8'h01);
	assign last_step = (step_q == nacc_q - 2'd1);
	assign load_out = (state_q == ST_FINISH) && (!out_valid_q || m_tready);

	// Sequencer: next state and RAM access.
	always_comb begin
		state_d = state_q;
		ram_req = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_d = ST_ACCESS;
				end
			end
			ST_ACCESS: begin
				ram_req.en = 1'b1;
				ram_req.we = is_push_q;
				ram_req.addr = is_push_q ? sp_q : sp_step;
				ram_req.wdata = push_byte_q[step_q];
				if (last_step) begin
					state_d = ST_FINISH;
				end
			end
			ST_FINISH: begin
				if (load_out) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Stack pointer, step counter and read tracking.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sp_q <= SIU_SP_RESET;
			step_q <= 2'd0;
			rd_pending_q <= 1'b0;
			rd_idx_q <= 2'd0;
		end else begin
			rd_pending_q <= (state_q == ST_ACCESS) && !is_push_q;
			if (accept) begin
				step_q <= 2'd0;
			end else if (state_q == ST_ACCESS) begin
				sp_q <= sp_step;
				step_q <= step_q + 2'd1;
				rd_idx_q <= step_q;
			end
		end
	end

	// Instruction word held for the whole sequence.
	always_ff @(posedge clk) begin
		if (accept) begin
			req_q <= req_in;
			pc_q <= in_pc;
			acc_q <= in_acc;
			st_q <= in_st;
			tgt_q <= in_tgt;
			kind_q <= in_kind;
			nmi_q <= s_tdata[50];
			nacc_q <= nacc_in;
			is_push_q <= is_push_in;
			for (int i = 0; i < 3; i++) begin
				push_byte_q[i] <= push_byte_in[i];
			end
		end
		if (rd_pending_q) begin
			pulled_q[rd_idx_q] <= ram_rdata;
		end
	end

	// Pulled bytes, with the read still in flight forwarded.
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			pull_v[i] = (rd_pending_q && rd_idx_q == 2'(i)) ? ram_rdata : pulled_q[i];
		end
	end

	// Result of the instruction.
	always_comb begin
		logic [15:0] pc_r;
		logic [15:0] ret_addr;
		logic [7:0] acc_r;
		logic [7:0] st_r;
		logic [7:0] pulled_st;
		logic nmi_sel;
		logic nmi_r;
		logic dset_r;
		logic dval_r;
		pc_r = pc_q;
		acc_r = acc_q;
		st_r = st_q;
		nmi_r = 1'b0;
		dset_r = 1'b0;
		dval_r = 1'b0;
		nmi_sel = nmi_q || (kind_q == KIND_NMI);
		pulled_st = pull_v[0] & ~(FLAG_U | FLAG_B);
		ret_addr = {pull_v[1], pull_v[0]} + 16'd1;
		unique case (req_q)
			REQ_ENTRY: begin
				pc_r = nmi_sel ? nmi_vec_q : irq_vec_q;
				st_r = st_q | FLAG_I;
				nmi_r = nmi_sel;
			end
			REQ_RTI: begin
				st_r = pulled_st;
				pc_r = {pull_v[2], pull_v[1]};
			end
			REQ_RTS: pc_r = ret_addr;
			REQ_PHA, REQ_PHP: pc_r = pc_q;
			REQ_PLA: begin
				acc_r = pull_v[0];
				st_r = (st_q & ~(FLAG_N | FLAG_Z)) | (pull_v[0] & FLAG_N)
					| ((pull_v[0] == 8'h00) ? FLAG_Z : 8'h00);
			end
			REQ_PLP: begin
				dset_r = 1'b1;
				dval_r = |(pulled_st & FLAG_I);
				st_r = (pulled_st & ~FLAG_I) | (st_q & FLAG_I);
			end
			REQ_JSR: pc_r = tgt_q;
			default: pc_r = pc_q;
		endcase
		res = {dval_r, dset_r, nmi_r, sp_q, st_r, acc_r, pc_r};
	end

	// Output register: holds a finished word until the consumer takes it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_q <= res;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata = {5'd0, out_q};

	// Vector registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nmi_vec_q <= 16'h0000;
			irq_vec_q <= 16'h0000;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_NMI_VECTOR: nmi_vec_q <= cfg_data;
				CFG_IRQ_BRK_VECTOR: irq_vec_q <= cfg_data;
				default: nmi_vec_q <= nmi_vec_q;
			endcase
		end
	end

	siu_stack_ram #(
		.STACK_DEPTH(STACK_DEPTH)
	) u_stack_ram (
		.clk(clk),
		.arst_n(arst_n),
		.req(ram_req),
		.rdata(ram_rdata)
	);

endmodule

// ----- tb/tb_top.sv -----
// Self-checking testbench for the stack instruction unit: random stack programs checked against a predictor.
`timescale 1ns / 100ps

module tb_top;
	import siu_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam int DRAIN_CYCLES = 8;
	localparam int REPORT_CAP = 40;

	// One stack instruction as it travels on the input stream
	typedef struct packed {
		siu_req_t    req;
		logic [15:0] pc;
		logic [7:0]  acc;
		logic [7:0]  status;
		logic [15:0] target;
		logic [1:0]  kind;
		logic        nmi_pending;
		logic        irq_pending;
	} stack_op_t;

	// Register state after one instruction
	typedef struct packed {
		logic [15:0] pc;
		logic [7:0]  acc;
		logic [7:0]  status;
		logic [7:0]  sp;
		logic        nmi_taken;
		logic        delay_set;
		logic        delay_value;
	} cpu_state_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [55:0] s_tdata = '0;
	logic [2:0]  s_tuser = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [47:0] m_tdata;
	logic        cfg_we = 1'b0;
	logic        cfg_index = CFG_NMI_VECTOR;
	logic [15:0] cfg_data = '0;

	// Predictor state: stack pointer, page-one RAM and both vectors
	logic [7:0]  stack_sp = SIU_SP_RESET;
	logic [7:0]  stack_mem [0:SIU_STACK_DEPTH-1];
	logic [15:0] nmi_vec = '0;
	logic [15:0] irq_vec = '0;

	stack_op_t   pending_ops[$];
	cpu_state_t  states_due[$];
	siu_req_t    open_frames[$];
	stack_op_t   drv_word;
	int          gap_pct = 32;
	int          mismatches = 0;
	int          results_checked = 0;
	int          ops_sent = 0;
	int          cycles = 0;

	stack_instruction_unit_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	initial begin
		for (int i = 0; i < SIU_STACK_DEPTH; i++)
			stack_mem[i] = 8'h00;
	end

	function automatic void push_byte(logic [7:0] value);
		stack_mem[stack_sp] = value;
		stack_sp = stack_sp - 8'd1;
	endfunction

	function automatic logic [7:0] pull_byte();
		stack_sp = stack_sp + 8'd1;
		return stack_mem[stack_sp];
	endfunction

	// Runs one instruction on the predictor state and returns the registers after it.
	function automatic cpu_state_t execute_stack_op(stack_op_t op);
		cpu_state_t  r;
		logic [15:0] pc;
		logic [7:0]  st;
		logic [7:0]  lo;
		logic [7:0]  hi;
		logic [7:0]  pulled;
		r = '0;
		pc = op.pc;
		st = op.status;
		r.acc = op.acc;
		case (op.req)
			REQ_ENTRY: begin
				// BRK skips its padding byte; entry kind 3 behaves like IRQ.
				if (op.kind == KIND_BRK)
					pc = pc + 16'd1;
				push_byte(pc[15:8]);
				push_byte(pc[7:0]);
				push_byte(st | FLAG_U | ((op.kind == KIND_BRK) ? FLAG_B : 8'h00));
				if (op.nmi_pending || op.kind == KIND_NMI) begin
					r.nmi_taken = 1'b1;
					pc = nmi_vec;
				end else begin
					pc = irq_vec;
				end
				st = st | FLAG_I;
			end
			REQ_RTI: begin
				st = pull_byte() & ~(FLAG_B | FLAG_U);
				lo = pull_byte();
				hi = pull_byte();
				pc = {hi, lo};
			end
			REQ_RTS: begin
				lo = pull_byte();
				hi = pull_byte();
				pc = {hi, lo} + 16'd1;
			end
			REQ_PHA: push_byte(op.acc);
			REQ_PHP: push_byte(st | FLAG_U | FLAG_B);
			REQ_PLA: begin
				r.acc = pull_byte();
				st = (st & ~(FLAG_N | FLAG_Z)) | (r.acc & FLAG_N) |
					((r.acc == 8'h00) ? FLAG_Z : 8'h00);
			end
			REQ_PLP: begin
				// The pulled I bit only takes effect later; the old one stays.
				pulled = pull_byte() & ~(FLAG_B | FLAG_U);
				r.delay_set = 1'b1;
				r.delay_value = (pulled & FLAG_I) != 8'h00;
				st = (pulled & ~FLAG_I) | (st & FLAG_I);
			end
			REQ_JSR: begin
				pc = pc + 16'd1;
				push_byte(pc[15:8]);
				push_byte(pc[7:0]);
				pc = op.target;
			end
		endcase
		r.pc = pc;
		r.status = st;
		r.sp = stack_sp;
		return r;
	endfunction

	function automatic stack_op_t random_op(siu_req_t req);
		stack_op_t op;
		op.req = req;
		op.pc = 16'($urandom_range(16'hFFFF));
		op.acc = 8'($urandom_range(8'hFF));
		op.status = 8'($urandom_range(8'hFF));
		op.target = 16'($urandom_range(16'hFFFF));
		op.kind = 2'($urandom_range(3));
		op.nmi_pending = 1'($urandom_range(1));
		op.irq_pending = 1'($urandom_range(1));
		return op;
	endfunction

	function automatic siu_req_t pick_opener();
		case ($urandom_range(3))
			0: return REQ_ENTRY;
			1: return REQ_JSR;
			2: return REQ_PHA;
			default: return REQ_PHP;
		endcase
	endfunction

	function automatic siu_req_t closer_of(siu_req_t opener);
		case (opener)
			REQ_ENTRY: return REQ_RTI;
			REQ_JSR: return REQ_RTS;
			REQ_PHA: return REQ_PLA;
			default: return REQ_PLP;
		endcase
	endfunction

	// Mostly nested push/pull frames with random content, plus some noise.
	// A low close chance drives the stack down, a high one drives it back up.
	task automatic queue_program(int count, int close_pct);
		siu_req_t req;
		repeat (count) begin
			if ($urandom_range(99) < 10) begin
				req = siu_req_t'(3'($urandom_range(7)));
			end else if ($urandom_range(99) < close_pct) begin
				if (open_frames.size() != 0)
					req = open_frames.pop_back();
				else
					req = closer_of(pick_opener());
			end else begin
				req = pick_opener();
				open_frames.push_back(closer_of(req));
			end
			pending_ops.push_back(random_op(req));
		end
	endtask

	task automatic queue_directed(siu_req_t req, logic [15:0] pc, logic [7:0] acc,
		logic [7:0] status, logic [1:0] kind, logic nmi_pending);
		stack_op_t op;
		op = random_op(req);
		op.pc = pc;
		op.acc = acc;
		op.status = status;
		op.kind = kind;
		op.nmi_pending = nmi_pending;
		pending_ops.push_back(op);
	endtask

	// Checked between edges, once the driver and monitor have settled.
	task automatic wait_drained();
		do
			@(negedge clk);
		while (pending_ops.size() != 0 || s_tvalid || states_due.size() != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_vectors(logic [15:0] nmi_value, logic [15:0] irq_value);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= CFG_NMI_VECTOR;
		cfg_data <= nmi_value;
		@(posedge clk);
		cfg_index <= CFG_IRQ_BRK_VECTOR;
		cfg_data <= irq_value;
		@(posedge clk);
		cfg_we <= 1'b0;
		nmi_vec = nmi_value;
		irq_vec = irq_value;
	endtask

	task automatic compare_field(string name, logic [15:0] want, logic [15:0] got);
		if (want !== got) begin
			mismatches++;
			if (mismatches <= REPORT_CAP)
				$display("%0t ns: %s mismatch, expected %h, got %h", $time, name, want, got);
		end
	endtask

	// Stimulus: directed checks under the reset vectors, then random phases.
	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// Pulls of zero and negative bytes, status round trips, PC wrap.
		queue_directed(REQ_PHA, 16'h0000, 8'h00, 8'h00, 2'd0, 1'b0);
		queue_directed(REQ_PLA, 16'hFFFF, 8'h5A, 8'h80, 2'd0, 1'b0);
		queue_directed(REQ_PHA, 16'h0000, 8'h80, 8'h00, 2'd0, 1'b0);
		queue_directed(REQ_PLA, 16'h0000, 8'h00, 8'h02, 2'd0, 1'b0);
		queue_directed(REQ_PHP, 16'h0000, 8'h00, 8'h00, 2'd0, 1'b0);
		queue_directed(REQ_PLP, 16'h0000, 8'h00, 8'h04, 2'd0, 1'b0);
		queue_directed(REQ_PHP, 16'hFFFF, 8'hFF, 8'hFF, 2'd3, 1'b1);
		queue_directed(REQ_PLP, 16'h0000, 8'h00, 8'h00, 2'd0, 1'b0);
		queue_directed(REQ_JSR, 16'hFFFF, 8'h00, 8'h00, 2'd0, 1'b0);
		queue_directed(REQ_RTS, 16'h0000, 8'h00, 8'h00, 2'd0, 1'b0);
		queue_directed(REQ_PHA, 16'h0000, 8'hFF, 8'h00, 2'd0, 1'b0);
		queue_directed(REQ_PHA, 16'h0000, 8'hFF, 8'h00, 2'd0, 1'b0);
		queue_directed(REQ_RTS, 16'h1234, 8'h00, 8'h00, 2'd0, 1'b0);
		// Every entry kind without a pending NMI, BRK and kind 3 also with one, each undone by RTI.
		queue_directed(REQ_ENTRY, 16'hFFFF, 8'h00, 8'h00, KIND_BRK, 1'b0);
		queue_directed(REQ_RTI, 16'h0000, 8'h00, 8'hFF, 2'd0, 1'b0);
		queue_directed(REQ_ENTRY, 16'hABCD, 8'h11, 8'hFF, 2'd1, 1'b0);
		queue_directed(REQ_RTI, 16'h0000, 8'h00, 8'h00, 2'd0, 1'b0);
		queue_directed(REQ_ENTRY, 16'h8000, 8'h22, 8'h00, KIND_NMI, 1'b0);
		queue_directed(REQ_RTI, 16'h0000, 8'h00, 8'h00, 2'd0, 1'b0);
		queue_directed(REQ_ENTRY, 16'h7FFF, 8'h33, 8'hCB, 2'd3, 1'b0);
		queue_directed(REQ_RTI, 16'h0000, 8'h00, 8'h00, 2'd0, 1'b0);
		queue_directed(REQ_ENTRY, 16'h0001, 8'h44, 8'h00, KIND_BRK, 1'b1);
		queue_directed(REQ_RTI, 16'h0000, 8'h00, 8'h00, 2'd0, 1'b0);
		queue_directed(REQ_ENTRY, 16'hFFFE, 8'h55, 8'h00, 2'd3, 1'b1);
		queue_directed(REQ_RTI, 16'h0000, 8'h00, 8'h00, 2'd0, 1'b0);
		wait_drained();

		// Push-heavy run that wraps the stack pointer downwards.
		write_vectors(16'hFFFF, 16'h0000);
		queue_program(200, 10);
		wait_drained();

		// Pull-heavy run with no idling on either side, wrapping back up.
		gap_pct = 0;
		write_vectors(16'h0000, 16'hFFFF);
		queue_program(200, 90);
		wait_drained();
		gap_pct = 32;

		// Balanced runs under random vectors.
		repeat (3) begin
			write_vectors(16'($urandom_range(16'hFFFF)), 16'($urandom_range(16'hFFFF)));
			queue_program(175, 50);
			wait_drained();
		end

		$display("%0d stack instructions sent over 6 vector settings, %0d results checked.",
			ops_sent, results_checked);
		$display("Stack pointer wrapped both ways; %0d field mismatches.", mismatches);
		if (mismatches == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

	// Input driver: presents queued words, idling at random between them.
	always @(posedge clk) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else begin
			if (s_tvalid && s_tready) begin
				states_due.push_back(execute_stack_op(drv_word));
				ops_sent++;
			end
			if (!s_tvalid || s_tready) begin
				if (pending_ops.size() != 0 && $urandom_range(99) >= gap_pct) begin
					drv_word = pending_ops.pop_front();
					s_tvalid <= 1'b1;
					s_tuser <= drv_word.req;
					s_tdata <= {4'b0000, drv_word.irq_pending, drv_word.nmi_pending,
						drv_word.kind, drv_word.target, drv_word.status,
						drv_word.acc, drv_word.pc};
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// Result monitor: stalls at random and checks each word against the oldest prediction.
	always @(posedge clk) begin
		cpu_state_t want;
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (states_due.size() == 0) begin
					mismatches++;
					$display("%0t ns: unexpected result word, expected none, got %h",
						$time, m_tdata);
				end else begin
					want = states_due.pop_front();
					results_checked++;
					compare_field("pc_out", want.pc, m_tdata[15:0]);
					compare_field("acc_out", 16'(want.acc), 16'(m_tdata[23:16]));
					compare_field("status_out", 16'(want.status), 16'(m_tdata[31:24]));
					compare_field("sp_out", 16'(want.sp), 16'(m_tdata[39:32]));
					compare_field("nmi_taken", 16'(want.nmi_taken), 16'(m_tdata[40]));
					compare_field("delay_set", 16'(want.delay_set), 16'(m_tdata[41]));
					compare_field("delay_value", 16'(want.delay_value), 16'(m_tdata[42]));
				end
			end
			m_tready <= ($urandom_range(99) >= gap_pct);
		end
	end

	// Watchdog on the whole run.
	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles with %0d results outstanding.",
				cycles, states_due.size());
			$display("TEST FAILED");
			$finish;
		end
	end

endmodule

// ----- sim.f -----
rtl/core/siu_pkg.sv
rtl/core/siu_stack_ram.sv
rtl/core/stack_instruction_unit_top.sv
tb/tb_top.sv
